// ===== src/brle_pkg.sv =====
// shared types, constants and the run code function of the bilevel run-length encoder
`default_nettype none
package brle_pkg;

  localparam int KEY_BITS   = 5;
  localparam int DIM_BITS   = 16;
  localparam int CNT_BITS   = 32;
  localparam int CODE_BITS  = 37;
  localparam int LEN_BITS   = 6;
  localparam int THR_BITS   = 8;
  localparam int CH_BITS    = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HDR_LEN    = 2 * DIM_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [CNT_BITS-1:0] RUN_LIMIT = 32'h8000_0000;
  localparam logic [CNT_BITS-1:0] CNT_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CNT_BITS-1:0] white_total;
    logic [DIM_BITS-1:0] box_left;
    logic [DIM_BITS-1:0] box_right;
    logic [DIM_BITS-1:0] box_top;
    logic [DIM_BITS-1:0] box_bottom;
  } stats_t;

  // one accepted pixel's worth of results
  typedef struct packed {
    logic                first_valid;
    logic                first_is_hdr;
    logic [CNT_BITS-1:0] first_run;
    logic [DIM_BITS-1:0] hdr_width;
    logic [DIM_BITS-1:0] hdr_height;
    logic                hdr_white;
    logic                last_valid;
    logic [CNT_BITS-1:0] last_run;
    stats_t              stats;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] bits;
    logic [LEN_BITS-1:0]  len;
    logic                 ovf;
  } code_t;

  // key k is the smallest k with run <= 2^k, then the run in k+1 bits
  function automatic code_t encode_run(input logic [CNT_BITS-1:0] run);
    code_t               c;
    logic [CNT_BITS-1:0] m;
    logic [KEY_BITS-1:0] k;
    logic [LEN_BITS-1:0] sh;
    c = '0;
    m = run - CNT_BITS'(1);
    k = '0;
    for (int i = 0; i < CNT_BITS - 1; i++) begin
      if (m[i]) k = KEY_BITS'(i + 1);
    end
    if (run == '0) k = '0;
    sh = LEN_BITS'(k) + LEN_BITS'(1);
    if (run > RUN_LIMIT) begin
      c.bits = '0;
      c.len  = LEN_BITS'(1);
      c.ovf  = 1'b1;
    end else begin
      c.bits = (CODE_BITS'(k) << sh) | CODE_BITS'(run);
      c.len  = LEN_BITS'(KEY_BITS) + sh;
      c.ovf  = 1'b0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/brle_front.sv =====
// front end: classifies pixels, tracks runs, counts and bounding box
`default_nettype none
module brle_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [brle_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic [brle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire brle_pkg::q_status_t            q_status,
  output logic                                push,
  output brle_pkg::entry_t                    push_entry
);
  import brle_pkg::*;

  logic [DIM_BITS-1:0] width_r, height_r;
  logic [THR_BITS-1:0] thresh_r;
  logic [DIM_BITS-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [CNT_BITS-1:0] run_r, run_nxt, wc_r, wc_nxt;
  logic                run_white_r, started_r, started_nxt;
  logic [DIM_BITS-1:0] left_r, right_r, top_r, bottom_r;
  logic [DIM_BITS-1:0] left_nxt, right_nxt, top_nxt, bottom_nxt;

  logic [CH_BITS-1:0]  red, green, blue;
  logic                accept, white, first, closed, last;
  logic [DIM_BITS-1:0] col_e, row_e;
  logic [CNT_BITS-1:0] run_base, wc_base;
  logic [DIM_BITS:0]   col_inc, row_inc;

  assign red       = in_tdata[7:0];
  assign green     = in_tdata[15:8];
  assign blue      = in_tdata[23:16];
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    white    = !(red < thresh_r && green < thresh_r && blue < thresh_r);
    first    = !started_r;
    closed   = !first && (white != run_white_r);
    col_e    = first ? '0 : col_r;
    row_e    = first ? '0 : row_r;
    run_base = (first || closed) ? '0 : run_r;
    wc_base  = first ? '0 : wc_r;
    left_nxt   = first ? width_r : left_r;
    right_nxt  = first ? '0 : right_r;
    top_nxt    = first ? height_r : top_r;
    bottom_nxt = first ? '0 : bottom_r;
    run_nxt  = (run_base == CNT_MAX) ? run_base : run_base + CNT_BITS'(1);
    wc_nxt   = wc_base;
    if (white) begin
      if (wc_base != CNT_MAX) wc_nxt = wc_base + CNT_BITS'(1);
      if (col_e < left_nxt)   left_nxt   = col_e;
      if (col_e > right_nxt)  right_nxt  = col_e;
      if (row_e < top_nxt)    top_nxt    = row_e;
      if (row_e > bottom_nxt) bottom_nxt = row_e;
    end
    col_inc = {1'b0, col_e} + (DIM_BITS+1)'(1);
    row_inc = {1'b0, row_e} + (DIM_BITS+1)'(1);
    last    = 1'b0;
    col_nxt = col_inc[DIM_BITS-1:0];
    row_nxt = row_e;
    if (col_inc >= {1'b0, width_r}) begin
      col_nxt = '0;
      if (row_inc >= {1'b0, height_r}) begin
        last    = 1'b1;
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[DIM_BITS-1:0];
      end
    end
    started_nxt = !last;

    push                          = accept && (first || closed || last);
    push_entry.first_valid        = first || closed;
    push_entry.first_is_hdr       = first;
    push_entry.first_run          = run_r;
    push_entry.hdr_width          = width_r;
    push_entry.hdr_height         = height_r;
    push_entry.hdr_white          = white;
    push_entry.last_valid         = last;
    push_entry.last_run           = run_nxt;
    push_entry.stats.white_total  = wc_nxt;
    push_entry.stats.box_left     = left_nxt;
    push_entry.stats.box_right    = right_nxt;
    push_entry.stats.box_top      = top_nxt;
    push_entry.stats.box_bottom   = bottom_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_BITS'(1);
      height_r    <= DIM_BITS'(1);
      thresh_r    <= THR_BITS'(32);
      col_r       <= '0;
      row_r       <= '0;
      run_r       <= '0;
      run_white_r <= 1'b0;
      started_r   <= 1'b0;
      wc_r        <= '0;
      left_r      <= DIM_BITS'(1);
      right_r     <= '0;
      top_r       <= DIM_BITS'(1);
      bottom_r    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:     width_r  <= cfg_data;
          CFG_HEIGHT:    height_r <= cfg_data;
          CFG_THRESHOLD: thresh_r <= cfg_data[THR_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        run_r       <= last ? '0 : run_nxt;
        run_white_r <= white;
        started_r   <= started_nxt;
        wc_r        <= wc_nxt;
        left_r      <= left_nxt;
        right_r     <= right_nxt;
        top_r       <= top_nxt;
        bottom_r    <= bottom_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/brle_queue.sv =====
// two-entry queue between front end and code emitter
`default_nettype none
module brle_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire brle_pkg::entry_t    push_entry,
  input  wire logic                pop,
  output brle_pkg::entry_t         head,
  output brle_pkg::q_status_t      q_status
);
  import brle_pkg::*;

  entry_t     entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign head           = entry_r[rd_ptr_r];
  assign q_status.empty = (count_r == 2'd0);
  assign q_status.full  = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/brle_back.sv =====
// back end: turns queued entries into header and run codes
`default_nettype none
module brle_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire brle_pkg::entry_t                head,
  input  wire brle_pkg::q_status_t             q_status,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [brle_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [brle_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);
  import brle_pkg::*;

  logic                 valid_r, phase_r, phase_nxt;
  logic [CODE_BITS-1:0] bits_r, bits_nxt;
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  logic                 hdr_r, hdr_nxt, ovf_r, ovf_nxt, done_r, done_nxt;
  stats_t               stats_r;
  logic                 load, emit, sel_first;
  logic [CNT_BITS-1:0]  run_sel;
  code_t                rc;

  always_comb begin
    load      = !valid_r || out_tready;
    emit      = load && !q_status.empty;
    sel_first = !phase_r && head.first_valid;
    run_sel   = sel_first ? head.first_run : head.last_run;
    rc        = encode_run(run_sel);
    pop       = emit && !(sel_first && head.last_valid);
    phase_nxt = phase_r;
    if (emit) phase_nxt = sel_first && head.last_valid;
    if (sel_first && head.first_is_hdr) begin
      bits_nxt = CODE_BITS'({head.hdr_width, head.hdr_height, head.hdr_white});
      len_nxt  = LEN_BITS'(HDR_LEN);
      hdr_nxt  = 1'b1;
      ovf_nxt  = 1'b0;
    end else begin
      bits_nxt = rc.bits;
      len_nxt  = rc.len;
      hdr_nxt  = 1'b0;
      ovf_nxt  = rc.ovf;
    end
    done_nxt = !sel_first;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bits_r  <= bits_nxt;
      len_r   <= len_nxt;
      hdr_r   <= hdr_nxt;
      ovf_r   <= ovf_nxt;
      done_r  <= done_nxt;
      stats_r <= head.stats;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (load) valid_r <= !q_status.empty;
      phase_r <= phase_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = done_r;
  assign out_tuser  = {ovf_r, hdr_r};
  assign out_tdata  = {5'd0, stats_r.box_bottom, stats_r.box_top, stats_r.box_right,
                       stats_r.box_left, stats_r.white_total, len_r, bits_r};

endmodule
`default_nettype wire

// ===== src/bilevel_run_length_encoder_core.sv =====
// top level of the bilevel run-length encoder
// Takes one RGB pixel per cycle in raster order and emits a header code on the first
// pixel of an image, one code per closed run, and the final run code with tlast set on
// the last pixel. A pixel is accepted every cycle while the queue has room, and a code
// is offered on out_tvalid once its entry has passed through the queue and the output
// register. The emitter sends one code per cycle while the output is not stalled, so a
// pixel that yields two codes keeps its queue entry until both are sent. A two-entry
// queue between the pixel front end and the emitter absorbs that and short output
// stalls; in_tready drops only while the queue is full. Configuration writes are taken
// at once (cfg_ready is always high) and must only happen while the block is idle.
`default_nettype none
module bilevel_run_length_encoder_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [brle_pkg::IN_DATA_W-1:0]   in_tdata,   // red, green, blue
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // code_bits, code_len, white_total, box_left, box_right, box_top, box_bottom
  output logic [brle_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [brle_pkg::OUT_USER_W-1:0]       out_tuser,  // is_header, run_overflow
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [brle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [brle_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brle_pkg::*;

  q_status_t q_status;
  entry_t    push_entry, head;
  logic      push, pop;

  assign cfg_ready = 1'b1;

  brle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  brle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  brle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_hdr_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[42:37] == 6'd33 && !out_tlast && !out_tuser[1])
    else $error("header code malformed");

  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[42:37] == 6'd1 && out_tdata[36:0] == '0)
    else $error("overflow code malformed");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[1] |-> out_tdata[42:37] >= 6'd6)
    else $error("run code too short");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire
